@@ hw/rtl/sts_pkg.sv @@
// ----------------------------------------------------------------------------
// Schedule table package
// Shared types and codes of the sorted time schedule table.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int HourW    = 5;
  localparam int MinuteW  = 6;
  localparam int PortionW = 16;
  localparam int KeyW     = 11;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_EVALUATE = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RC_OK        = 2'd0,
    RC_FULL      = 2'd1,
    RC_DUPLICATE = 2'd2,
    RC_BAD_INDEX = 2'd3
  } code_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_REMOVE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [HourW-1:0]    hour;
    logic [MinuteW-1:0]  minute;
    logic [PortionW-1:0] portion;
  } entry_t;

  // Result of the shared compare unit
  typedef struct packed {
    logic            eq;
    logic            gt;
    logic [KeyW-1:0] probe_key;
  } cmp_t;

endpackage

@@ hw/rtl/sts_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sts_ram #(
  parameter int Width = 27,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  logic [Width-1:0]      wdata_i,
  input  logic                  re_i,
  input  logic [AddrW-1:0]      raddr_i,
  output logic [Width-1:0]      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ hw/rtl/sts_cmp.sv @@
// ----------------------------------------------------------------------------
// Schedule compare unit
// Compares one stored entry with the time of the current request.
// ----------------------------------------------------------------------------
module sts_cmp
  import sts_pkg::*;
(
  input  entry_t             entry_i,
  input  logic [HourW-1:0]   hour_i,
  input  logic [MinuteW-1:0] minute_i,
  output cmp_t               cmp_o
);

  localparam logic [KeyW-1:0] MinutesPerHour = KeyW'(60);

  logic [KeyW-1:0] entry_key;
  logic [KeyW-1:0] probe_key;

  // Minute of day; out-of-range inputs still fit in eleven bits
  assign entry_key = KeyW'(entry_i.hour) * MinutesPerHour + KeyW'(entry_i.minute);
  assign probe_key = KeyW'(hour_i) * MinutesPerHour + KeyW'(minute_i);

  assign cmp_o.eq        = (entry_i.hour == hour_i) && (entry_i.minute == minute_i);
  assign cmp_o.gt        = entry_key > probe_key;
  assign cmp_o.probe_key = probe_key;

endmodule

@@ hw/rtl/sorted_time_schedule_table_top.sv @@
// ----------------------------------------------------------------------------
// Sorted time schedule table
// Keeps timed events sorted by minute of day; insert, remove and evaluate.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+--------------------------------------
//  request   | start, busy               | operation, hour, minute, portion, index
//  result    | result_valid_o (strobe)   | code, match fields, entries held
//
//  One request runs under a sequencer around one RAM read port and one compare
//  unit, one table entry per cycle. Insert runs a duplicate scan, then shifts
//  later entries up from the top; remove moves the entries above the index down;
//  evaluate scans for a match; an insert into a full table or a bad remove index
//  goes straight to the result. busy stays high through the result strobe.
//  Reset clears the entry count; table contents are never read before written.
//  The result is shown for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module sorted_time_schedule_table_top
  import sts_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          operation_i,
  input  logic [HourW-1:0]    hour_of_day_i,
  input  logic [MinuteW-1:0]  minute_of_hour_i,
  input  logic [PortionW-1:0] portion_amount_i,
  input  logic [3:0]          entry_index_i,
  output logic                result_valid_o,
  output logic [1:0]          result_code_o,
  output logic                matched_o,
  output logic [PortionW-1:0] matched_portion_o,
  output logic [HourW-1:0]    matched_hour_o,
  output logic [MinuteW-1:0]  matched_minute_o,
  output logic [4:0]          entries_held_o
);

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CmpW = (CW > 4) ? CW : 4;

  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [HourW-1:0]    hour_q, hour_d;
  logic [MinuteW-1:0]  minute_q, minute_d;
  logic [PortionW-1:0] portion_q, portion_d;
  logic [CW-1:0]       total_q, total_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [AW-1:0]       ra_q, ra_d;
  logic                vld_q, vld_d;
  logic                hit_q, hit_d;
  entry_t              match_q, match_d;
  code_e               code_q, code_d;
  logic [KeyW-1:0]     last_q, last_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  entry_t        ram_rdata;
  cmp_t          cmp;

  logic          accept;
  logic          table_full;
  logic          index_bad;
  logic          sweep_end;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;
  logic          is_eval;

  assign busy       = state_q != ST_IDLE;
  assign accept     = start && !busy;
  assign table_full = total_q >= CW'(TABLE_DEPTH);
  assign index_bad  = CmpW'(entry_index_i) >= CmpW'(total_q);
  assign sweep_end  = (cnt_q >= total_q) && !vld_q;
  assign cnt_m1     = cnt_q - CW'(1);
  assign cnt_m2     = cnt_q - CW'(2);

  sts_ram #(
    .Width($bits(entry_t)),
    .Depth(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ra_d),
    .rdata_o(ram_rdata)
  );

  sts_cmp u_cmp (
    .entry_i (ram_rdata),
    .hour_i  (hour_q),
    .minute_i(minute_q),
    .cmp_o   (cmp)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_e'(operation_i))
            OP_INSERT:   state_d = table_full ? ST_DONE : ST_SCAN;
            OP_REMOVE:   state_d = index_bad ? ST_DONE : ST_REMOVE;
            OP_EVALUATE: state_d = ST_SCAN;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (sweep_end) begin
          state_d = (op_q == OP_INSERT && !hit_q) ? ST_INS_RD : ST_DONE;
        end
      end
      ST_INS_RD:  state_d = (cnt_q == '0) ? ST_INS_PUT : ST_INS_CMP;
      ST_INS_CMP: begin
        if (!cmp.gt || cnt_m1 == '0) begin
          state_d = ST_INS_PUT;
        end
      end
      ST_INS_PUT: state_d = ST_DONE;
      ST_REMOVE: begin
        if (sweep_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    op_d      = op_q;
    hour_d    = hour_q;
    minute_d  = minute_q;
    portion_d = portion_q;
    total_d   = total_q;
    cnt_d     = cnt_q;
    ra_d      = ra_q;
    vld_d     = 1'b0;
    hit_d     = hit_q;
    match_d   = match_q;
    code_d    = code_q;
    last_d    = last_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = cnt_q[AW-1:0];
    ram_wdata = ram_rdata;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d      = op_e'(operation_i);
          hour_d    = hour_of_day_i;
          minute_d  = minute_of_hour_i;
          portion_d = portion_amount_i;
          cnt_d     = '0;
          hit_d     = 1'b0;
          match_d   = '0;
          code_d    = RC_OK;
          if (op_e'(operation_i) == OP_INSERT && table_full) begin
            code_d = RC_FULL;
          end
          if (op_e'(operation_i) == OP_REMOVE) begin
            if (index_bad) begin
              code_d = RC_BAD_INDEX;
            end else begin
              // read the entry just above the one being dropped
              cnt_d = CW'(entry_index_i) + CW'(1);
            end
          end
        end
      end
      ST_SCAN: begin
        if (cnt_q < total_q) begin
          ram_re = 1'b1;
          ra_d   = cnt_q[AW-1:0];
          vld_d  = 1'b1;
          cnt_d  = cnt_q + CW'(1);
        end
        if (vld_q && cmp.eq) begin
          hit_d   = 1'b1;
          match_d = ram_rdata;
        end
        if (sweep_end) begin
          if (op_q == OP_INSERT) begin
            if (hit_q) begin
              code_d = RC_DUPLICATE;
            end else begin
              cnt_d = total_q;
            end
          end else if (hit_q) begin
            last_d = cmp.probe_key;
          end
        end
      end
      ST_INS_RD: begin
        if (cnt_q != '0) begin
          ram_re = 1'b1;
          ra_d   = cnt_m1[AW-1:0];
        end
      end
      ST_INS_CMP: begin
        // move a later entry up one slot and fetch the next one below
        if (cmp.gt) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_q[AW-1:0];
          ram_wdata = ram_rdata;
          cnt_d     = cnt_m1;
          if (cnt_m1 != '0) begin
            ram_re = 1'b1;
            ra_d   = cnt_m2[AW-1:0];
          end
        end
      end
      ST_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[AW-1:0];
        ram_wdata = '{hour: hour_q, minute: minute_q, portion: portion_q};
        total_d   = total_q + CW'(1);
      end
      ST_REMOVE: begin
        if (cnt_q < total_q) begin
          ram_re = 1'b1;
          ra_d   = cnt_q[AW-1:0];
          vld_d  = 1'b1;
          cnt_d  = cnt_q + CW'(1);
        end
        if (vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = ra_q - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (sweep_end) begin
          total_d = total_q - CW'(1);
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= '0;
      last_q  <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      last_q  <= last_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    hour_q    <= hour_d;
    minute_q  <= minute_d;
    portion_q <= portion_d;
    cnt_q     <= cnt_d;
    ra_q      <= ra_d;
    hit_q     <= hit_d;
    match_q   <= match_d;
    code_q    <= code_d;
  end

  assign is_eval           = (op_q == OP_EVALUATE) && hit_q;
  assign result_valid_o    = state_q == ST_DONE;
  assign result_code_o     = code_q;
  assign matched_o         = is_eval;
  assign matched_portion_o = is_eval ? match_q.portion : '0;
  assign matched_hour_o    = is_eval ? match_q.hour : '0;
  assign matched_minute_o  = is_eval ? match_q.minute : '0;
  assign entries_held_o    = 5'(total_q);

endmodule

@@ hw/rtl/sts_checker.sv @@
// ----------------------------------------------------------------------------
// Schedule table checker
// Port-level checks on request and result sequencing.
// ----------------------------------------------------------------------------
module sts_checker
  import sts_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                result_valid_o,
  input logic [1:0]          result_code_o,
  input logic                matched_o,
  input logic [PortionW-1:0] matched_portion_o,
  input logic [HourW-1:0]    matched_hour_o,
  input logic [MinuteW-1:0]  matched_minute_o
);

  // an accepted request holds the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // a result only closes a running request
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe while idle");

  a_result_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o && !busy)
    else $error("result strobe longer than one cycle");

  a_reject_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_code_o != RC_OK |-> !matched_o)
    else $error("rejected request reports a match");

  a_no_match_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !matched_o |->
      matched_portion_o == '0 && matched_hour_o == '0 && matched_minute_o == '0)
    else $error("match fields not cleared without a match");

endmodule

bind sorted_time_schedule_table_top sts_checker u_sts_checker (.*);

@@ tb/sv/tb_sorted_time_schedule_table_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Schedule table testbench
// Sends insert, remove, evaluate and no-op requests with random gaps and checks every
// result strobe against a cycle-free model of the sorted event table or a typed result.
// ----------------------------------------------------------------------------
module tb_sorted_time_schedule_table_top
  import sts_pkg::*;
;

  localparam int TableDepth     = 16;
  localparam int RandomRequests = 1550;
  localparam int CycleLimit     = 600000;
  localparam int DrainCycles    = 50;

  typedef struct packed {
    code_e               code;
    logic                matched;
    logic [PortionW-1:0] portion;
    logic [HourW-1:0]    hour;
    logic [MinuteW-1:0]  minute;
    logic [4:0]          held;
  } outcome_t;

  typedef struct {
    op_e                 op;
    logic [HourW-1:0]    hour;
    logic [MinuteW-1:0]  minute;
    logic [PortionW-1:0] portion;
    logic [3:0]          index;
    bit                  typed;
    outcome_t            want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [1:0]          operation_i;
  logic [HourW-1:0]    hour_of_day_i;
  logic [MinuteW-1:0]  minute_of_hour_i;
  logic [PortionW-1:0] portion_amount_i;
  logic [3:0]          entry_index_i;
  logic                result_valid_o;
  logic [1:0]          result_code_o;
  logic                matched_o;
  logic [PortionW-1:0] matched_portion_o;
  logic [HourW-1:0]    matched_hour_o;
  logic [MinuteW-1:0]  matched_minute_o;
  logic [4:0]          entries_held_o;

  // Model of the table contents
  entry_t          sched_tbl [TableDepth];
  int              sched_count = 0;
  logic [KeyW-1:0] last_dispense_min = '0;

  outcome_t  pending_outcomes [$];
  stim_row_t directed_rows [$];
  outcome_t  checked_outcome;
  int        fail_cnt = 0;
  int        cycle_cnt = 0;
  bit        calm = 1'b0;

  sorted_time_schedule_table_top #(
    .TABLE_DEPTH(TableDepth)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .hour_of_day_i    (hour_of_day_i),
    .minute_of_hour_i (minute_of_hour_i),
    .portion_amount_i (portion_amount_i),
    .entry_index_i    (entry_index_i),
    .result_valid_o   (result_valid_o),
    .result_code_o    (result_code_o),
    .matched_o        (matched_o),
    .matched_portion_o(matched_portion_o),
    .matched_hour_o   (matched_hour_o),
    .matched_minute_o (matched_minute_o),
    .entries_held_o   (entries_held_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
    fail_cnt++;
  endtask

  function automatic int day_minute(input logic [HourW-1:0] h, input logic [MinuteW-1:0] m);
    return int'(h) * 60 + int'(m);
  endfunction

  // Apply one request to the model table and return the result it gives
  function automatic outcome_t predict_outcome(input op_e op,
                                               input logic [HourW-1:0] hr,
                                               input logic [MinuteW-1:0] mn,
                                               input logic [PortionW-1:0] por,
                                               input logic [3:0] idx);
    outcome_t o;
    bit       dup;
    int       pos;
    int       key;
    o = '0;
    o.code = RC_OK;
    dup = 1'b0;
    key = day_minute(hr, mn);
    case (op)
      OP_INSERT: begin
        if (sched_count >= TableDepth) begin
          o.code = RC_FULL;
        end else begin
          for (int i = 0; i < sched_count; i++) begin
            if (sched_tbl[i].hour == hr && sched_tbl[i].minute == mn) dup = 1'b1;
          end
          if (dup) begin
            o.code = RC_DUPLICATE;
          end else begin
            // shift larger keys up; equal keys stay in front of the new entry
            pos = sched_count;
            while (pos > 0 &&
                   day_minute(sched_tbl[pos-1].hour, sched_tbl[pos-1].minute) > key) begin
              sched_tbl[pos] = sched_tbl[pos-1];
              pos--;
            end
            sched_tbl[pos].hour    = hr;
            sched_tbl[pos].minute  = mn;
            sched_tbl[pos].portion = por;
            sched_count++;
          end
        end
      end
      OP_REMOVE: begin
        if (int'(idx) >= sched_count) begin
          o.code = RC_BAD_INDEX;
        end else begin
          for (int i = int'(idx); i + 1 < sched_count; i++) sched_tbl[i] = sched_tbl[i+1];
          sched_count--;
        end
      end
      OP_EVALUATE: begin
        for (int i = 0; i < sched_count; i++) begin
          if (sched_tbl[i].hour == hr && sched_tbl[i].minute == mn) begin
            o.matched = 1'b1;
            o.portion = sched_tbl[i].portion;
            o.hour    = sched_tbl[i].hour;
            o.minute  = sched_tbl[i].minute;
            last_dispense_min = KeyW'(key);
          end
        end
      end
      default: ;
    endcase
    o.held = 5'(sched_count);
    return o;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with no request pending", 1, 0);
      end else begin
        checked_outcome = pending_outcomes.pop_front();
        if (result_code_o !== checked_outcome.code)
          report_mismatch("result_code", int'(result_code_o),
                          int'(checked_outcome.code));
        if (matched_o !== checked_outcome.matched)
          report_mismatch("matched", int'(matched_o), int'(checked_outcome.matched));
        if (matched_portion_o !== checked_outcome.portion)
          report_mismatch("matched_portion", int'(matched_portion_o),
                          int'(checked_outcome.portion));
        if (matched_hour_o !== checked_outcome.hour)
          report_mismatch("matched_hour", int'(matched_hour_o),
                          int'(checked_outcome.hour));
        if (matched_minute_o !== checked_outcome.minute)
          report_mismatch("matched_minute", int'(matched_minute_o),
                          int'(checked_outcome.minute));
        if (entries_held_o !== checked_outcome.held)
          report_mismatch("entries_held", int'(entries_held_o),
                          int'(checked_outcome.held));
      end
    end
  end

  task automatic add_row(input op_e op, input int hr, input int mn, input int por,
                         input int idx, input bit typed, input code_e code,
                         input int matched, input int mp, input int mh, input int mm,
                         input int held);
    stim_row_t r;
    r.op           = op;
    r.hour         = HourW'(hr);
    r.minute       = MinuteW'(mn);
    r.portion      = PortionW'(por);
    r.index        = 4'(idx);
    r.typed        = typed;
    r.want.code    = code;
    r.want.matched = matched[0];
    r.want.portion = PortionW'(mp);
    r.want.hour    = HourW'(mh);
    r.want.minute  = MinuteW'(mm);
    r.want.held    = 5'(held);
    directed_rows.push_back(r);
  endtask

  // Drive one request, hold it until accepted, then queue its expected result
  task automatic issue_request(input op_e op, input logic [HourW-1:0] hr,
                               input logic [MinuteW-1:0] mn,
                               input logic [PortionW-1:0] por, input logic [3:0] idx,
                               input bit typed, input outcome_t want);
    outcome_t predicted;
    int       gap;
    if (!calm && $urandom_range(0, 99) < 24) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start            <= 1'b1;
    operation_i      <= op;
    hour_of_day_i    <= hr;
    minute_of_hour_i <= mn;
    portion_amount_i <= por;
    entry_index_i    <= idx;
    do @(posedge clk_i); while (busy);
    predicted = predict_outcome(op, hr, mn, por, idx);
    pending_outcomes.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random();
    int                  counted;
    int                  mood;
    int                  pick;
    bit                  paused;
    op_e                 op;
    logic [HourW-1:0]    hr;
    logic [MinuteW-1:0]  mn;
    logic [PortionW-1:0] por;
    logic [3:0]          idx;
    counted = 0;
    mood    = 0;
    paused  = 1'b0;
    while (counted < RandomRequests) begin
      if (counted % 48 == 0) mood = $urandom_range(0, 2);
      calm = (counted >= 500 && counted < 800);
      if (counted == 1000 && !paused) begin
        paused = 1'b1;
        wait_drained();
      end
      // mood 0 fills the table, mood 1 drains it, mood 2 mixes
      pick = $urandom_range(0, 99);
      if (pick < 5)                                           op = OP_NONE;
      else if (pick < (mood == 0 ? 70 : mood == 1 ? 25 : 45)) op = OP_INSERT;
      else if (pick < (mood == 0 ? 90 : mood == 1 ? 45 : 75)) op = OP_EVALUATE;
      else                                                    op = OP_REMOVE;
      hr  = HourW'($urandom_range(0, 31));
      mn  = MinuteW'($urandom_range(0, 63));
      por = PortionW'($urandom_range(0, 65535));
      idx = 4'($urandom_range(0, 15));
      // a small pool of times makes duplicates and a full table common
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        hr = HourW'($urandom_range(0, 3));
        mn = MinuteW'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(58, 63));
      end else if (pick == 5) begin
        hr = HourW'($urandom_range(0, 30));
        mn = MinuteW'(($urandom_range(0, 1) ? 60 : 0) + $urandom_range(0, 3));
      end
      if (op == OP_EVALUATE && sched_count > 0 && $urandom_range(0, 99) < 60) begin
        pick = $urandom_range(0, sched_count - 1);
        hr   = sched_tbl[pick].hour;
        mn   = sched_tbl[pick].minute;
      end
      if (op == OP_REMOVE && sched_count > 0 && $urandom_range(0, 99) < 85)
        idx = 4'($urandom_range(0, sched_count - 1));
      issue_request(op, hr, mn, por, idx, 1'b0, '0);
      if (op != OP_NONE) counted++;
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni           = 1'b0;
    start            = 1'b0;
    operation_i      = OP_NONE;
    hour_of_day_i    = '0;
    minute_of_hour_i = '0;
    portion_amount_i = '0;
    entry_index_i    = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // op, hour, minute, portion, index, typed, code, matched, portion, hour, minute, held
    add_row(OP_EVALUATE,  0,  0, 'h0000,  0, 1, RC_OK,        0, 'h0000,  0,  0, 0);
    add_row(OP_REMOVE,    0,  0, 'h0000,  0, 1, RC_BAD_INDEX, 0, 'h0000,  0,  0, 0);
    add_row(OP_NONE,     31, 63, 'hffff, 15, 1, RC_OK,        0, 'h0000,  0,  0, 0);
    add_row(OP_INSERT,   23, 59, 'hffff, 15, 1, RC_OK,        0, 'h0000,  0,  0, 1);
    add_row(OP_INSERT,    0,  0, 'h0000,  0, 1, RC_OK,        0, 'h0000,  0,  0, 2);
    add_row(OP_INSERT,    0, 60, 'h1234,  0, 1, RC_OK,        0, 'h0000,  0,  0, 3);
    add_row(OP_INSERT,    1,  0, 'h0100,  0, 1, RC_OK,        0, 'h0000,  0,  0, 4);
    add_row(OP_INSERT,    1,  0, 'habcd,  0, 1, RC_DUPLICATE, 0, 'h0000,  0,  0, 4);
    add_row(OP_INSERT,   31, 63, 'h8000,  0, 1, RC_OK,        0, 'h0000,  0,  0, 5);
    add_row(OP_EVALUATE,  1,  0, 'h0000,  0, 1, RC_OK,        1, 'h0100,  1,  0, 5);
    add_row(OP_EVALUATE,  0, 60, 'h0000,  0, 1, RC_OK,        1, 'h1234,  0, 60, 5);
    add_row(OP_EVALUATE, 31, 63, 'h0000,  0, 1, RC_OK,        1, 'h8000, 31, 63, 5);
    add_row(OP_REMOVE,    0,  0, 'h0000, 15, 1, RC_BAD_INDEX, 0, 'h0000,  0,  0, 5);
    add_row(OP_REMOVE,    0,  0, 'h0000,  5, 1, RC_BAD_INDEX, 0, 'h0000,  0,  0, 5);
    add_row(OP_REMOVE,    0,  0, 'h0000,  4, 0, RC_OK,        0, 'h0000,  0,  0, 0);
    add_row(OP_REMOVE,    0,  0, 'h0000,  1, 0, RC_OK,        0, 'h0000,  0,  0, 0);
    add_row(OP_EVALUATE, 12, 30, 'h0000,  0, 1, RC_OK,        0, 'h0000,  0,  0, 3);
    add_row(OP_NONE,      1,  0, 'h0000,  0, 1, RC_OK,        0, 'h0000,  0,  0, 3);
    add_row(OP_INSERT,   12, 30, 'h7fff,  0, 0, RC_OK,        0, 'h0000,  0,  0, 0);
    add_row(OP_INSERT,   12, 29, 'h0001,  0, 0, RC_OK,        0, 'h0000,  0,  0, 0);
    add_row(OP_INSERT,   12, 31, 'h00ff,  0, 0, RC_OK,        0, 'h0000,  0,  0, 0);
    add_row(OP_REMOVE,    0,  0, 'h0000,  0, 0, RC_OK,        0, 'h0000,  0,  0, 0);
    add_row(OP_EVALUATE, 23, 59, 'h0000,  0, 0, RC_OK,        0, 'h0000,  0,  0, 0);
    add_row(OP_INSERT,    1, 60, 'h0080,  0, 0, RC_OK,        0, 'h0000,  0,  0, 0);
    add_row(OP_INSERT,    2,  0, 'h0040,  0, 0, RC_OK,        0, 'h0000,  0,  0, 0);
    add_row(OP_EVALUATE,  1, 60, 'h0000,  0, 0, RC_OK,        0, 'h0000,  0,  0, 0);

    foreach (directed_rows[i]) begin
      issue_request(directed_rows[i].op, directed_rows[i].hour, directed_rows[i].minute,
                    directed_rows[i].portion, directed_rows[i].index,
                    directed_rows[i].typed, directed_rows[i].want);
    end
    wait_drained();
    run_random();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/sts_pkg.sv
hw/rtl/sts_ram.sv
hw/rtl/sts_cmp.sv
hw/rtl/sorted_time_schedule_table_top.sv
hw/rtl/sts_checker.sv
tb/sv/tb_sorted_time_schedule_table_top.sv
